// ===== src/block_cache_set_assoc_lookup_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block cache lookup
// Property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CACHE_SET_ASSOC_LOOKUP_MACROS_SVH
`define BLOCK_CACHE_SET_ASSOC_LOOKUP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BCL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcl: same-cycle check failed");
// next-cycle implication
`define BCL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcl: next-cycle check failed");
`else
`define BCL_ASSERT_NOW(lbl, ante, cons)
`define BCL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/bcl_pkg.sv =====
// ----------------------------------------------------------------------------
// bcl_pkg
// Types and constants shared by the block cache lookup and its channels.
// ----------------------------------------------------------------------------
package bcl_pkg;

	localparam int ADDR_W      = 32;
	localparam int OFS_W       = 25;
	localparam int SET_IDX_W   = 8;
	localparam int WAY_IDX_W   = 2;
	localparam int ACTION_W    = 2;
	localparam int HASH_SHIFT_LO = 2;
	localparam int HASH_SHIFT_HI = 16;

	typedef logic [ACTION_W-1:0] action_t;

	localparam action_t ACT_LOOKUP    = 2'd0;
	localparam action_t ACT_RECOMPILE = 2'd1;
	localparam action_t ACT_FLUSH     = 2'd2;

	typedef struct packed {
		action_t           action;
		logic [ADDR_W-1:0] address;
		logic              compile_ok;
		logic              arena_flushed;
		logic [OFS_W-1:0]  new_code_offset;
		logic [OFS_W-1:0]  new_chain_offset;
	} in_word_t;

	typedef struct packed {
		logic                 found;
		logic                 hit;
		logic [SET_IDX_W-1:0] set_index;
		logic [WAY_IDX_W-1:0] way_index;
		logic [OFS_W-1:0]     entry_code;
		logic [OFS_W-1:0]     entry_chain;
	} out_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] tag;
		logic [OFS_W-1:0]  code;
		logic [OFS_W-1:0]  chain;
	} entry_t;

	// unmasked set hash; caller keeps the low set bits
	function automatic logic [ADDR_W-1:0] set_hash(input logic [ADDR_W-1:0] addr);
		return (addr >> HASH_SHIFT_LO) ^ (addr >> HASH_SHIFT_HI);
	endfunction

endpackage

// ===== src/bcl_if.sv =====
// ----------------------------------------------------------------------------
// bcl channel interfaces
// Valid/ready channels for lookup words, result words and config writes.
// ----------------------------------------------------------------------------
interface bcl_lookup_if
	import bcl_pkg::*;
;
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bcl_result_if
	import bcl_pkg::*;
;
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bcl_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/block_cache_set_assoc_lookup.sv =====
// ----------------------------------------------------------------------------
// block_cache_set_assoc_lookup
// Set-associative tag store for translated code blocks, round-robin refill.
// ----------------------------------------------------------------------------
// A lookup word first reads the whole set row synchronously (tags,
// offsets, valid bits), then goes to compare, victim choice, write-back
// and loading the result register. A new lookup word is taken only
// when the previous one has left the compare stage, so lookup words do
// not overlap; a result that is not taken holds the compare stage.
// Valid bits live in a NUM_SETS x NUM_WAYS memory and are cleared by a
// sweep of one set per cycle after reset, after a flush word, and after
// a fill that reports an arena flush. No lookup word is taken during the
// sweep; config writes are.
// Set = ((address >> 2) ^ (address >> 16)) mod NUM_SETS (a power of two).
// Victim: the hit way on a forced recompile, else the highest empty way,
// else the round-robin way for a plain lookup, way 0 for a recompile.
// ----------------------------------------------------------------------------
`include "block_cache_set_assoc_lookup_macros.svh"

module block_cache_set_assoc_lookup
	import bcl_pkg::*;
#(
	parameter int NUM_SETS = 256,
	parameter int NUM_WAYS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	bcl_lookup_if.sink    lookup,
	bcl_result_if.source  result,
	bcl_cfg_if.sink       cfg
);

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);
	localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);

	typedef entry_t [NUM_WAYS-1:0] row_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_LOOK  = 3'b010,
		ST_SWEEP = 3'b100
	} state_t;

	// set memories
	row_t                data_mem [NUM_SETS];
	logic [NUM_WAYS-1:0] vld_mem  [NUM_SETS];

	state_t              state_q;
	logic                dis_q;
	logic [WAY_W-1:0]    rr_q;
	logic [SET_W-1:0]    sweep_cnt_q;
	logic [SET_W-1:0]    keep_set_q;
	logic [NUM_WAYS-1:0] keep_mask_q;
	logic                out_valid_q;
	out_word_t           out_q;

	// stage 1: registered read data and the word being worked on
	in_word_t            item_s1;
	logic [SET_W-1:0]    set_s1;
	row_t                row_s1;
	logic [NUM_WAYS-1:0] vld_s1;

	logic                accept;
	logic [SET_W-1:0]    rd_set;
	logic                done;

	logic [NUM_WAYS-1:0] hit_vec;
	logic                hit_any;
	logic [WAY_W-1:0]    hit_way;
	logic                empty_any;
	logic [WAY_W-1:0]    empty_way;
	logic                is_lookup;
	logic                recompile;
	logic                found_hit;
	logic                do_fill;
	logic                rr_adv;
	logic [WAY_W-1:0]    victim;
	logic [NUM_WAYS-1:0] victim_mask;
	logic [NUM_WAYS-1:0] vld_new;
	row_t                row_new;
	logic                go_sweep;
	out_word_t           res;

	logic                vld_we;
	logic [SET_W-1:0]    vld_waddr;
	logic [NUM_WAYS-1:0] vld_wdata;

	// ---- handshakes ----
	assign lookup.ready = (state_q == ST_IDLE);
	assign accept       = lookup.valid && lookup.ready;
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	assign rd_set = SET_W'(set_hash(lookup.data.address) & ADDR_W'(NUM_SETS - 1));

	// compare stage completes when the result register is free
	assign done = (state_q == ST_LOOK) && (!out_valid_q || result.ready);

	// ---- compare and victim choice ----
	always_comb begin
		hit_way   = '0;
		empty_way = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			hit_vec[w] = vld_s1[w] && (row_s1[w].tag == item_s1.address);
		end
		// lowest matching way
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = WAY_W'(w);
			end
		end
		// highest empty way
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!vld_s1[w]) begin
				empty_way = WAY_W'(w);
			end
		end
		hit_any   = |hit_vec;
		empty_any = ~&vld_s1;
	end

	always_comb begin
		is_lookup = (item_s1.action == ACT_LOOKUP) || (item_s1.action == ACT_RECOMPILE);
		recompile = (item_s1.action == ACT_RECOMPILE);
		found_hit = is_lookup && !dis_q && hit_any && !recompile;
		do_fill   = is_lookup && !dis_q && !found_hit;
		rr_adv    = do_fill && !recompile && !hit_any && !empty_any;

		if (recompile && hit_any) begin
			victim = hit_way;
		end else if (empty_any) begin
			victim = empty_way;
		end else if (!recompile) begin
			victim = rr_q;
		end else begin
			victim = '0;
		end

		victim_mask = '0;
		victim_mask[victim] = 1'b1;

		vld_new = (vld_s1 & ~victim_mask) | (item_s1.compile_ok ? victim_mask : '0);

		row_new = row_s1;
		row_new[victim] = '{tag: item_s1.address,
			code: item_s1.new_code_offset,
			chain: item_s1.new_chain_offset};

		go_sweep = (item_s1.action == ACT_FLUSH) || (do_fill && item_s1.arena_flushed);

		res = '0;
		if (is_lookup) begin
			res.set_index = SET_IDX_W'(set_s1);
		end
		if (found_hit) begin
			res.found       = 1'b1;
			res.hit         = 1'b1;
			res.way_index   = WAY_IDX_W'(hit_way);
			res.entry_code  = row_s1[hit_way].code;
			res.entry_chain = row_s1[hit_way].chain;
		end else if (do_fill) begin
			res.way_index = WAY_IDX_W'(victim);
			if (item_s1.compile_ok) begin
				res.found       = 1'b1;
				res.entry_code  = item_s1.new_code_offset;
				res.entry_chain = item_s1.new_chain_offset;
			end
		end
	end

	// ---- valid memory write port: sweep or single-set update ----
	always_comb begin
		vld_we    = 1'b0;
		vld_waddr = set_s1;
		vld_wdata = vld_new;
		if (state_q == ST_SWEEP) begin
			vld_we    = 1'b1;
			vld_waddr = sweep_cnt_q;
			vld_wdata = (sweep_cnt_q == keep_set_q) ? keep_mask_q : '0;
		end else if (done && do_fill && !item_s1.arena_flushed) begin
			vld_we = 1'b1;
		end
	end

	// ---- memories ----
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= data_mem[rd_set];
			vld_s1 <= vld_mem[rd_set];
		end
		if (done && do_fill) begin
			data_mem[set_s1] <= row_new;
		end
		if (vld_we) begin
			vld_mem[vld_waddr] <= vld_wdata;
		end
	end

	// ---- payload of the word in flight ----
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= lookup.data;
			set_s1  <= rd_set;
		end
		if (done) begin
			out_q <= res;
		end
	end

	// ---- control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;      // clearing pass after reset
			dis_q       <= 1'b0;
			rr_q        <= '0;
			sweep_cnt_q <= '0;
			keep_set_q  <= '0;
			keep_mask_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				dis_q <= cfg.data;
			end

			if (done) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (done && rr_adv) begin
				rr_q <= (rr_q == LAST_WAY) ? '0 : rr_q + 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (done) begin
						if (go_sweep) begin
							state_q     <= ST_SWEEP;
							sweep_cnt_q <= '0;
							keep_set_q  <= set_s1;
							// victim survives an arena flush when its fill succeeds
							keep_mask_q <= (do_fill && item_s1.compile_ok) ? victim_mask : '0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SWEEP: begin
					if (sweep_cnt_q == LAST_SET) begin
						state_q <= ST_IDLE;
					end else begin
						sweep_cnt_q <= sweep_cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---- checks ----
	// a tag is never held valid in two ways of one set
	`BCL_ASSERT_NOW(a_single_match, state_q == ST_LOOK, $onehot0(hit_vec))
	// round-robin pointer stays inside the way count
	`BCL_ASSERT_NOW(a_rr_range, 1'b1, rr_q <= LAST_WAY)
	// a hit always reports a found entry
	`BCL_ASSERT_NOW(a_hit_found, out_valid_q && out_q.hit, out_q.found)
	// the sweep hands back to idle after its last set
	`BCL_ASSERT_NEXT(a_sweep_end, state_q == ST_SWEEP && sweep_cnt_q == LAST_SET,
		state_q == ST_IDLE)

endmodule
